// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the projection core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PVP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pvp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PVP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pvp assertion failed");

`endif

// ----- design/pvp_pkg.sv -----
// ----------------------------------------------------------------------------
// pvp_pkg
// Types and constants shared by the perspective projection pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pvp_pkg;

    localparam int DIV_STEPS = 16;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_ROT_ROW0     = 3'd0;
    localparam logic [2:0] CFG_ROT_ROW1     = 3'd1;
    localparam logic [2:0] CFG_ROT_ROW2     = 3'd2;
    localparam logic [2:0] CFG_TRANSLATION  = 3'd3;
    localparam logic [2:0] CFG_PROJ_DIST    = 3'd4;
    localparam logic [2:0] CFG_OFFSET_X     = 3'd5;
    localparam logic [2:0] CFG_OFFSET_Y     = 3'd6;

    // Reset values: identity matrix, no translation, distance 0x200
    localparam logic [47:0] ROT_ROW0_RST    = 48'h0000_0000_0001;
    localparam logic [47:0] ROT_ROW1_RST    = 48'h0000_0001_0000;
    localparam logic [47:0] ROT_ROW2_RST    = 48'h0001_0000_0000;
    localparam logic [47:0] TRANSLATION_RST = 48'h0;
    localparam logic [15:0] PROJ_DIST_RST   = 16'h0200;
    localparam logic [15:0] OFFSET_RST      = 16'h0;

    typedef struct packed {
        logic [15:0] vert_x;
        logic [15:0] vert_y;
        logic [15:0] vert_z;
    } t_vert_in;

    typedef struct packed {
        logic [15:0] screen_x;
        logic [15:0] screen_y;
        logic        div_by_zero;
    } t_screen_out;

    typedef struct packed {
        logic [2:0][47:0] rot_row;
        logic [47:0]      translation;
        logic [15:0]      proj_distance;
        logic [15:0]      offset_x;
        logic [15:0]      offset_y;
    } t_cfg;

    // Truncated rotation results
    typedef struct packed {
        logic [15:0] ir1;
        logic [15:0] ir2;
        logic [15:0] ir3;
    } t_rot_beat;

    // Divider result, low 16 bits of the signed quotient
    typedef struct packed {
        logic [15:0] ir1;
        logic [15:0] ir2;
        logic [15:0] quo;
        logic        dz;
    } t_div_beat;

    // One divider iteration stage
    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] num;
        logic [15:0] den;
        logic [15:0] quo;
        logic        neg;
        logic        dz;
        logic [15:0] ir1;
        logic [15:0] ir2;
    } t_div_stage;

endpackage

`default_nettype wire

// ----- design/pvp_rotate.sv -----
// ----------------------------------------------------------------------------
// pvp_rotate
// Matrix rotate and translate, low 16 bits of each row sum, two stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pvp_rotate
    import pvp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cfg      i_cfg,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_vert_in  i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_rot_beat      o_data
);

    logic             r_v1;
    logic [8:0][15:0] r_prod;
    logic             r_v2;
    t_rot_beat        r_out;

    logic             w_adv1;
    logic             w_adv2;
    logic [8:0][15:0] n_prod;
    t_rot_beat        n_out;
    logic [2:0][15:0] w_coord;

    assign w_adv2  = ~r_v2 | i_ready;
    assign w_adv1  = ~r_v1 | w_adv2;
    assign o_ready = w_adv1;
    assign o_valid = r_v2;
    assign o_data  = r_out;

    assign w_coord[0] = i_data.vert_x;
    assign w_coord[1] = i_data.vert_y;
    assign w_coord[2] = i_data.vert_z;

    // Only the low 16 bits survive truncation, so low product bits suffice.
    always_comb begin
        logic [31:0] prod;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                prod = {16'h0, i_cfg.rot_row[r][16*c +: 16]} * {16'h0, w_coord[c]};
                n_prod[3*r + c] = prod[15:0];
            end
        end
    end

    always_comb begin
        n_out.ir1 = i_cfg.translation[15:0]  + r_prod[0] + r_prod[1] + r_prod[2];
        n_out.ir2 = i_cfg.translation[31:16] + r_prod[3] + r_prod[4] + r_prod[5];
        n_out.ir3 = i_cfg.translation[47:32] + r_prod[6] + r_prod[7] + r_prod[8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_valid;
            if (w_adv2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) r_prod <= n_prod;
        if (w_adv2) r_out  <= n_out;
    end

endmodule

`default_nettype wire

// ----- design/pvp_divider.sv -----
// ----------------------------------------------------------------------------
// pvp_divider
// Pipelined signed divide of the projection distance by depth,
// one quotient bit per stage, truncating toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pvp_divider
    import pvp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic [15:0] i_proj_distance,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_rot_beat i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_div_beat      o_data
);

    // Stage 0 takes magnitudes, stages 1..DIV_STEPS iterate, last one fixes sign
    localparam int LAST = DIV_STEPS + 1;

    logic [LAST:0]            r_v;
    t_div_stage [DIV_STEPS:0] r_st;
    t_div_beat                r_out;
    logic [LAST+1:0]          w_adv;
    t_div_stage [DIV_STEPS:0] n_st;
    t_div_beat                n_out;

    assign w_adv[LAST+1] = i_ready;
    assign o_ready       = w_adv[0];
    assign o_valid       = r_v[LAST];
    assign o_data        = r_out;

    genvar k;
    generate
        for (k = 0; k <= LAST; k++) begin : g_adv
            assign w_adv[k] = ~r_v[k] | w_adv[k+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) r_v[0] <= i_valid;
            for (int s = 1; s <= LAST; s++) begin
                if (w_adv[s]) r_v[s] <= r_v[s-1];
            end
        end
    end

    // Stage 0 loads magnitudes; each later stage is one restoring step
    always_comb begin
        logic [16:0] trial;
        logic [16:0] diff;
        n_st[0].rem = 16'h0;
        n_st[0].num = i_proj_distance[15] ? (16'h0 - i_proj_distance) : i_proj_distance;
        n_st[0].den = i_data.ir3[15] ? (16'h0 - i_data.ir3) : i_data.ir3;
        n_st[0].quo = 16'h0;
        n_st[0].neg = i_proj_distance[15] ^ i_data.ir3[15];
        n_st[0].dz  = (i_data.ir3 == 16'h0);
        n_st[0].ir1 = i_data.ir1;
        n_st[0].ir2 = i_data.ir2;
        for (int s = 1; s <= DIV_STEPS; s++) begin
            trial       = {r_st[s-1].rem, r_st[s-1].num[15]};
            diff        = trial - {1'b0, r_st[s-1].den};
            n_st[s]     = r_st[s-1];
            n_st[s].num = {r_st[s-1].num[14:0], 1'b0};
            if (trial >= {1'b0, r_st[s-1].den}) begin
                n_st[s].rem = diff[15:0];
                n_st[s].quo = {r_st[s-1].quo[14:0], 1'b1};
            end else begin
                n_st[s].rem = trial[15:0];
                n_st[s].quo = {r_st[s-1].quo[14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s <= DIV_STEPS; s++) begin
            if (w_adv[s]) r_st[s] <= n_st[s];
        end
    end

    always_comb begin
        n_out.ir1 = r_st[DIV_STEPS].ir1;
        n_out.ir2 = r_st[DIV_STEPS].ir2;
        n_out.dz  = r_st[DIV_STEPS].dz;
        if (r_st[DIV_STEPS].dz) begin
            n_out.quo = 16'h0;
        end else if (r_st[DIV_STEPS].neg) begin
            n_out.quo = 16'h0 - r_st[DIV_STEPS].quo;
        end else begin
            n_out.quo = r_st[DIV_STEPS].quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[LAST]) r_out <= n_out;
    end

    // Remainder after the final step must be below the divisor
    `PVP_ASSERT_IMP(a_rem_lt_den, i_clk, i_rst_n,
        r_v[DIV_STEPS] && !r_st[DIV_STEPS].dz, r_st[DIV_STEPS].rem < r_st[DIV_STEPS].den)

endmodule

`default_nettype wire

// ----- design/pvp_scale.sv -----
// ----------------------------------------------------------------------------
// pvp_scale
// Scales ir1/ir2 by the quotient and adds the screen offsets, two stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pvp_scale
    import pvp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [15:0] i_offset_x,
    input  wire logic [15:0] i_offset_y,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_div_beat   i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_screen_out      o_data
);

    logic        r_v1;
    logic [15:0] r_px;
    logic [15:0] r_py;
    logic        r_dz;
    logic        r_v2;
    t_screen_out r_out;

    logic        w_adv1;
    logic        w_adv2;
    logic [31:0] w_mx;
    logic [31:0] w_my;

    assign w_adv2  = ~r_v2 | i_ready;
    assign w_adv1  = ~r_v1 | w_adv2;
    assign o_ready = w_adv1;
    assign o_valid = r_v2;
    assign o_data  = r_out;

    // Low 16 bits of a product do not depend on signedness
    assign w_mx = {16'h0, i_data.ir1} * {16'h0, i_data.quo};
    assign w_my = {16'h0, i_data.ir2} * {16'h0, i_data.quo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_valid;
            if (w_adv2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_px <= w_mx[15:0];
            r_py <= w_my[15:0];
            r_dz <= i_data.dz;
        end
        if (w_adv2) begin
            r_out.screen_x    <= i_offset_x + r_px;
            r_out.screen_y    <= i_offset_y + r_py;
            r_out.div_by_zero <= r_dz;
        end
    end

    // Zero depth leaves the offsets alone
    `PVP_ASSERT_IMP(a_dz_offsets, i_clk, i_rst_n,
        r_v2 && r_out.div_by_zero,
        r_out.screen_x == i_offset_x && r_out.screen_y == i_offset_y)

endmodule

`default_nettype wire

// ----- design/perspective_vertex_projection_core.sv -----
// ----------------------------------------------------------------------------
// perspective_vertex_projection_core
// Rotate, translate, perspective-project a vertex per clock unless stalled.
//
//   channel  direction  handshake                   payload
//   in       input      i_in_valid / o_in_ready     i_in_data  (t_vert_in)
//   out      output     o_out_valid / i_out_ready   o_out_data (t_screen_out)
//   cfg      input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One vertex beat accepted per cycle unless the output stalls. Stages run
// rotate, divide, scale; 16 radix-2 divider steps set the depth.
// Synchronous active-low reset clears the stage valid bits and loads the
// register defaults. Each stage moves when empty or when the next one moves,
// so a stall on the output fills bubbles before it stops intake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module perspective_vertex_projection_core
    import pvp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // vertex input
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_vert_in    i_in_data,
    // screen output
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_screen_out      o_out_data,
    // register writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data
);

    t_cfg      r_cfg;

    logic      w_rot_valid;
    logic      w_rot_ready;
    t_rot_beat w_rot_data;
    logic      w_div_valid;
    logic      w_div_ready;
    t_div_beat w_div_data;

    // Always ready. Users must change registers only while idle; not enforced.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rot_row[0]    <= ROT_ROW0_RST;
            r_cfg.rot_row[1]    <= ROT_ROW1_RST;
            r_cfg.rot_row[2]    <= ROT_ROW2_RST;
            r_cfg.translation   <= TRANSLATION_RST;
            r_cfg.proj_distance <= PROJ_DIST_RST;
            r_cfg.offset_x      <= OFFSET_RST;
            r_cfg.offset_y      <= OFFSET_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROT_ROW0:    r_cfg.rot_row[0]    <= i_cfg_data;
                CFG_ROT_ROW1:    r_cfg.rot_row[1]    <= i_cfg_data;
                CFG_ROT_ROW2:    r_cfg.rot_row[2]    <= i_cfg_data;
                CFG_TRANSLATION: r_cfg.translation   <= i_cfg_data;
                CFG_PROJ_DIST:   r_cfg.proj_distance <= i_cfg_data[15:0];
                CFG_OFFSET_X:    r_cfg.offset_x      <= i_cfg_data[15:0];
                CFG_OFFSET_Y:    r_cfg.offset_y      <= i_cfg_data[15:0];
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    // ir1..ir3 = low 16 bits of R * v + T
    pvp_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (w_rot_valid),
        .i_ready (w_rot_ready),
        .o_data  (w_rot_data)
    );

    // q = proj_distance / ir3, zero depth flagged
    pvp_divider u_divider (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_proj_distance (r_cfg.proj_distance),
        .i_valid         (w_rot_valid),
        .o_ready         (w_rot_ready),
        .i_data          (w_rot_data),
        .o_valid         (w_div_valid),
        .i_ready         (w_div_ready),
        .o_data          (w_div_data)
    );

    // screen = offset + ir * q, output register last
    pvp_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_offset_x (r_cfg.offset_x),
        .i_offset_y (r_cfg.offset_y),
        .i_valid    (w_div_valid),
        .o_ready    (w_div_ready),
        .i_data     (w_div_data),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (o_out_data)
    );

    // An empty output stage lets every stage move, so intake is open
    `PVP_ASSERT_IMP(a_ready_when_out_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)

endmodule

`default_nettype wire
